@@ rtl/sfla_pkg.sv @@
// Shared types and constants for the segregated free-list allocator.
package sfla_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BYPASS   = 2'd1;
   localparam logic [1:0] ST_NO_MEM   = 2'd2;
   localparam logic [1:0] ST_ZERO     = 2'd3;

   localparam int unsigned REFILL_RESET = 20;
   localparam int unsigned REFILL_MAX   = 64;

   // granule size in bytes; the size decode divides by shifting, so a power of two
   localparam int unsigned GRANULE_BYTES = 8;

   // Request word fields, highest bit first
   typedef struct packed {
      logic [15:0] block_addr;
      logic [15:0] size_bytes;
      logic        opcode;
   } req_word_type;

   // Response word fields, highest bit first
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_addr;
   } rsp_word_type;

endpackage

@@ rtl/segregated_free_list_allocator_core.sv @@
// Top level of the segregated free-list allocator: sequencer, head and link memories.
//
// One request word is handled at a time; req_tready is low from the accepting edge until the
// response word has been taken. A zero-size or oversize request or a free outside the arena
// goes from decode straight to the response; a free reads its class head and pushes the block,
// and an allocate from a non-empty class pops the head through its link. An empty class
// triggers a carve: the blocks that fit are counted by repeated subtraction, capped at
// refill_blocks (at most 64), and then linked with one link write per block after the first.
// When the pool is short, the leftover is pushed on the head of its own class and robbing
// walks the class heads upward from the request class. After reset a clearing pass over all
// NUM_CLASSES head entries empties the head memory before the first request.
module segregated_free_list_allocator_core #(
   parameter int unsigned MAX_CLASS_BYTES = 4096,
   parameter int unsigned NUM_CLASSES     = 512,
   parameter int unsigned ARENA_GRANULES  = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[0], size_bytes[16:1], block_addr[32:17], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // result_addr[15:0], status[17:16], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // refill_blocks[6:0], zero pad
);
   import sfla_pkg::*;

   localparam int unsigned CW = $clog2(NUM_CLASSES);
   localparam int unsigned AW = $clog2(ARENA_GRANULES) + 1;  // holds the arena size
   localparam int unsigned LW = $clog2(ARENA_GRANULES);
   localparam int unsigned GS = $clog2(GRANULE_BYTES);

   localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE  = 5'd1,  S_DEC   = 5'd2,
                          S_HRD   = 5'd3,  S_HWAIT = 5'd4,  S_POPL  = 5'd5,
                          S_PUSHL = 5'd6,  S_FIT   = 5'd7,  S_LEFT  = 5'd8,
                          S_ROBR  = 5'd9,  S_ROBW  = 5'd10, S_ROBL  = 5'd11,
                          S_LINK  = 5'd12, S_HEADW = 5'd13, S_RESP  = 5'd14,
                          S_POPLW = 5'd15, S_ROBLW = 5'd16, S_SPILL = 5'd17;

   logic [4:0]     state_ff, state_in;
   logic [6:0]     refill_ff;
   req_word_type   req_ff;
   logic [AW-1:0]  pool_start_ff, pool_end_ff;
   logic [CW-1:0]  cls_ff;          // request class
   logic [CW-1:0]  scan_ff;         // clear / rob walk index
   logic [AW-1:0]  g_ff;            // granules per block
   logic [AW:0]    head_ff;         // head read (addr + 1)
   logic [AW-1:0]  addr_ff;
   logic [AW-1:0]  left_ff;         // fit count working remainder
   logic [6:0]     n_ff, k_ff, fit_ff;
   logic           pass_ff;
   logic [AW-1:0]  blk_ff;          // block being linked
   logic [1:0]     status_ff;
   logic [15:0]    raddr_ff;
   logic           rsp_valid_ff;

   // memories
   logic [AW:0]    heads_mem [NUM_CLASSES];
   logic [AW:0]    links_mem [ARENA_GRANULES];
   logic [AW:0]    hrd_ff, lrd_ff;
   logic           hwe, lwe;
   logic [CW-1:0]  hwa, hra;
   logic [AW:0]    hwd, lwd;
   logic [LW-1:0]  lwa, lra;

   always_ff @(posedge clock) begin
      if (hwe) heads_mem[hwa] <= hwd;
      hrd_ff <= heads_mem[hra];
      if (lwe) links_mem[lwa] <= lwd;
      lrd_ff <= links_mem[lra];
   end

   req_word_type req_w;
   assign req_w = req_word_type'(req_tdata[32:0]);

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, status_ff, raddr_ff};

   // decode of the latched request
   logic [16:0]   gran17;
   logic          zero_sz, oversize;
   assign gran17   = ({1'b0, req_ff.size_bytes} + 17'(GRANULE_BYTES - 1)) >> GS;
   assign zero_sz  = req_ff.size_bytes == 16'd0;
   assign oversize = (req_ff.size_bytes > 16'(MAX_CLASS_BYTES > 65535 ? 65535 : MAX_CLASS_BYTES))
                     || (gran17 > 17'(NUM_CLASSES));

   logic [AW-1:0] pool_left, mul_blk;
   assign pool_left = (pool_end_ff > pool_start_ff) ? pool_end_ff - pool_start_ff : '0;

   logic [AW+1:0] free_end;
   assign free_end = (AW+2)'(req_ff.block_addr) + (AW+2)'(gran17);

   always_comb begin
      state_in = state_ff;
      hwe = 1'b0; hwa = cls_ff; hwd = '0; hra = cls_ff;
      lwe = 1'b0; lwa = '0; lwd = '0; lra = head_ff[LW-1:0] - LW'(1);
      mul_blk = blk_ff + g_ff;
      case (state_ff)
         S_CLEAR: begin
            hwe = 1'b1; hwa = scan_ff;
            if (scan_ff == CW'(NUM_CLASSES - 1)) state_in = S_IDLE;
         end
         S_IDLE:  if (req_tvalid && req_tready) state_in = S_DEC;
         S_DEC: begin
            if (zero_sz || oversize) state_in = S_RESP;
            else if (req_ff.opcode == OP_FREE && free_end > (AW+2)'(ARENA_GRANULES))
               state_in = S_RESP;
            else state_in = S_HRD;
         end
         S_HRD:   state_in = S_HWAIT;
         S_HWAIT: begin
            if (req_ff.opcode == OP_FREE) state_in = S_PUSHL;
            else if (hrd_ff != '0 && hrd_ff <= (AW+1)'(ARENA_GRANULES)) state_in = S_POPL;
            else state_in = S_LEFT;
         end
         S_PUSHL: begin
            // link the freed block to the old head, then make it the head
            lwe = 1'b1; lwa = LW'(req_ff.block_addr); lwd = head_ff;
            hwe = 1'b1; hwd = (AW+1)'(req_ff.block_addr) + (AW+1)'(1);
            state_in = S_RESP;
         end
         S_POPL:  state_in = S_POPLW;
         S_POPLW: begin
            hwe = 1'b1; hwd = lrd_ff;
            state_in = S_RESP;
         end
         S_LEFT: begin
            // pool check: carve, report out of memory after a rob, or read the leftover's class head and start robbing
            hra = CW'(pool_left - AW'(1));
            if (pool_left >= g_ff) state_in = S_FIT;
            else if (pass_ff) state_in = S_RESP;
            else if (pool_left != '0) state_in = S_SPILL;
            else state_in = S_ROBR;
         end
         S_SPILL: begin
            // leftover goes on the head of its own class
            hwe = 1'b1; hwa = CW'(pool_left - AW'(1));
            hwd = (AW+1)'(pool_start_ff) + (AW+1)'(1);
            lwe = 1'b1; lwa = pool_start_ff[LW-1:0]; lwd = hrd_ff;
            state_in = S_ROBR;
         end
         S_ROBR:  begin hra = scan_ff; state_in = S_ROBW; end
         S_ROBW: begin
            hra = scan_ff;
            if (hrd_ff != '0 && hrd_ff <= (AW+1)'(ARENA_GRANULES)) state_in = S_ROBL;
            else if (scan_ff == CW'(NUM_CLASSES - 1)) state_in = S_RESP;
            else state_in = S_ROBR;
         end
         S_ROBL:  state_in = S_ROBLW;
         S_ROBLW: begin
            hwe = 1'b1; hwa = scan_ff; hwd = lrd_ff;
            state_in = S_LEFT;
         end
         S_FIT: begin
            // fit count by repeated subtract, capped at n
            if (fit_ff == n_ff || left_ff < g_ff) state_in = S_LINK;
         end
         S_LINK: begin
            // link block k to block k+1; last block ends the list
            if (k_ff >= fit_ff) state_in = S_HEADW;
            else begin
               lwe = blk_ff < AW'(ARENA_GRANULES);
               lwa = blk_ff[LW-1:0];
               lwd = (k_ff + 7'd1 < fit_ff) ? (AW+1)'(mul_blk) + (AW+1)'(1) : '0;
            end
         end
         S_HEADW: begin
            if (fit_ff > 7'd1) begin
               hwe = 1'b1; hwd = (AW+1)'(addr_ff) + (AW+1)'(g_ff) + (AW+1)'(1);
            end
            state_in = S_RESP;
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         scan_ff       <= '0;
         refill_ff     <= 7'(REFILL_RESET);
         pool_start_ff <= '0;
         pool_end_ff   <= AW'(ARENA_GRANULES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) refill_ff <= csr_data[6:0];
         if (state_ff == S_RESP) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: scan_ff <= scan_ff + CW'(1);
            S_IDLE: if (req_tvalid && req_tready) begin
               req_ff <= req_w;
               pass_ff <= 1'b0;
               status_ff <= ST_OK;
               n_ff <= (req_w.opcode == OP_FREE) ? 7'd1 :
                       (refill_ff == 7'd0) ? 7'd1 :
                       (refill_ff > 7'(REFILL_MAX)) ? 7'(REFILL_MAX) : refill_ff;
            end
            S_DEC: begin
               g_ff   <= AW'(gran17);
               cls_ff <= CW'(gran17 - 17'd1);
               if (zero_sz) status_ff <= ST_ZERO;
               else if (oversize) status_ff <= ST_BYPASS;
               raddr_ff <= (req_ff.opcode == OP_FREE) ? req_ff.block_addr : 16'd0;
            end
            S_HWAIT: head_ff <= hrd_ff;
            S_POPLW: raddr_ff <= 16'(head_ff - (AW+1)'(1));
            S_LEFT: begin
               if (pool_left >= g_ff) begin
                  left_ff <= pool_left;
                  fit_ff  <= 7'd0;
                  addr_ff <= pool_start_ff;
               end else if (pass_ff) begin
                  status_ff <= ST_NO_MEM;
                  raddr_ff  <= 16'd0;
               end else if (pool_left == '0) begin
                  pool_start_ff <= pool_end_ff;
                  scan_ff <= cls_ff;
               end
            end
            S_SPILL: begin
               pool_start_ff <= pool_end_ff;
               scan_ff <= cls_ff;
            end
            S_ROBW: begin
               head_ff <= hrd_ff;
               if (hrd_ff != '0 && hrd_ff <= (AW+1)'(ARENA_GRANULES)) begin
                  pool_start_ff <= AW'(hrd_ff - (AW+1)'(1));
                  pool_end_ff   <= AW'(hrd_ff - (AW+1)'(1)) + AW'(scan_ff) + AW'(1);
               end else if (scan_ff == CW'(NUM_CLASSES - 1)) begin
                  status_ff <= ST_NO_MEM;
                  raddr_ff  <= 16'd0;
               end else scan_ff <= scan_ff + CW'(1);
            end
            S_ROBLW: pass_ff <= 1'b1;
            S_FIT: begin
               if (fit_ff == n_ff || left_ff < g_ff) begin
                  pool_start_ff <= blk_ff;
                  raddr_ff <= 16'(addr_ff);
                  blk_ff   <= addr_ff + g_ff;
                  k_ff     <= 7'd1;
               end else begin
                  left_ff <= left_ff - g_ff;
                  fit_ff  <= fit_ff + 7'd1;
                  blk_ff  <= (fit_ff == 7'd0 ? addr_ff : blk_ff) + g_ff;
               end
            end
            S_LINK: if (k_ff < fit_ff) begin
               blk_ff <= mul_blk;
               k_ff   <= k_ff + 7'd1;
            end
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/sfla_checker.sv @@
// Port-level checks for the allocator, bound to the top level.
module sfla_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import sfla_pkg::*;

   // no new word taken while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken with response pending");

   // accepted request is busy the next cycle
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready after accept");

   // out of memory reports a null address
   a_nomem_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[17:16] == ST_NO_MEM) |-> rsp_tdata[15:0] == 16'd0)
      else $error("out of memory with non-null address");

   // response holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response dropped while stalled");

endmodule

bind segregated_free_list_allocator_core sfla_checker u_sfla_checker (.*);
